@@ rtl/core/qle_pkg.sv @@
// Shared types, sizes and codes of the tabular Q-learning engine.
// Used by every module of the core; depends on nothing.
package qle_pkg;

   // table geometry
   localparam int NUM_STATES  = 256;
   localparam int NUM_ACTIONS = 5;
   localparam int TABLE_DEPTH = NUM_STATES * NUM_ACTIONS;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int STATE_W     = $clog2(NUM_STATES);
   localparam int COL_W       = $clog2(NUM_ACTIONS);

   // field widths
   localparam int OP_W    = 2;
   localparam int SIDX_W  = 8;
   localparam int ACT_W   = 3;
   localparam int Q_W     = 32;
   localparam int DRAW_W  = 16;
   localparam int RATE_W  = 17;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;

   // item opcodes
   localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
   localparam logic [OP_W-1:0] OP_CHOOSE = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_LEARN_RATE = 2'd0;
   localparam logic [1:0] REG_DISCOUNT   = 2'd1;
   localparam logic [1:0] REG_EXPLORE    = 2'd2;

   // register reset values
   localparam logic [RATE_W-1:0] LEARN_RATE_RST = 17'd52429;
   localparam logic [RATE_W-1:0] DISCOUNT_RST   = 17'd64881;
   localparam logic [RATE_W-1:0] EXPLORE_RST    = 17'd0;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [SIDX_W-1:0]        cur_state;
      logic [ACT_W-1:0]         taken_action;
      logic signed [Q_W-1:0]    reward_value;
      logic [SIDX_W-1:0]        next_state;
      logic [DRAW_W-1:0]        explore_draw;
      logic [ACT_W-1:0]         random_action;
      logic signed [Q_W-1:0]    entry_value;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0]         chosen_action;
      logic                     explored;
      logic signed [Q_W-1:0]    best_value;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0]        learn_rate;
      logic [RATE_W-1:0]        discount;
      logic [RATE_W-1:0]        explore_threshold;
   } cfg_type;

   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic [Q_W-1:0]           wdata;
      logic [ADDR_W-1:0]        raddr;
   } tbl_req_type;

   typedef enum logic [2:0] {
      UPD_IDLE,
      UPD_GAMMA,
      UPD_TARGET,
      UPD_ALPHA,
      UPD_SUM
   } upd_step_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_READ_Q,
      S_MUL_G,
      S_TARGET,
      S_MUL_A,
      S_SUM,
      S_WRITE,
      S_WR_ENTRY,
      S_RESULT
   } eng_state_type;

endpackage

@@ rtl/core/qle_csr.sv @@
// Configuration registers of the Q-learning engine behind an APB-style port.
// Depends on qle_pkg.
module qle_csr import qle_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready,
   output cfg_type            cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LEARN_RATE: cfg_in.learn_rate        = csr_pwdata[RATE_W-1:0];
            REG_DISCOUNT:   cfg_in.discount          = csr_pwdata[RATE_W-1:0];
            REG_EXPLORE:    cfg_in.explore_threshold = csr_pwdata[RATE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate        <= LEARN_RATE_RST;
         cfg_ff.discount          <= DISCOUNT_RST;
         cfg_ff.explore_threshold <= EXPLORE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_LEARN_RATE: csr_prdata = PDATA_W'(cfg_ff.learn_rate);
         REG_DISCOUNT:   csr_prdata = PDATA_W'(cfg_ff.discount);
         REG_EXPLORE:    csr_prdata = PDATA_W'(cfg_ff.explore_threshold);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/core/qle_table.sv @@
// Q table memory: one write and one registered read a cycle, plus the
// zero-fill sweep that runs after reset. Depends on qle_pkg.
module qle_table import qle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  tbl_req_type      tbl_req,
   output logic [Q_W-1:0]   rd_data,
   output logic             ready
);

   logic [Q_W-1:0]    mem_ff [TABLE_DEPTH];
   logic [Q_W-1:0]    rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clearing_ff, clearing_in;

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

   // clear sweep counter
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // storage array
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (tbl_req.we) begin
         mem_ff[tbl_req.waddr] <= tbl_req.wdata;
      end
      rd_data_ff <= mem_ff[tbl_req.raddr];
   end

endmodule

@@ rtl/core/qle_update.sv @@
// Q value update datapath: one shared multiplier stepped by the sequencer,
// new = sat(round((1-alpha)*q + alpha*(reward + round(gamma*max)))). Depends on qle_pkg.
module qle_update import qle_pkg::*; (
   input  logic                  clock,
   input  upd_step_type          step,
   input  cfg_type               cfg,
   input  logic signed [Q_W-1:0] row_max,
   input  logic [Q_W-1:0]        q_rd,
   input  logic signed [Q_W-1:0] reward,
   output logic [Q_W-1:0]        new_value
);

   localparam int A_W   = 35;
   localparam int B_W   = RATE_W + 1;
   localparam int P_W   = A_W + B_W;
   localparam int T_W   = 34;
   localparam int ACC_W = 51;
   localparam int GR_W  = 33;
   localparam int AR_W  = ACC_W - 16;

   logic signed [Q_W-1:0]   q_ff, q_in;
   logic signed [P_W-1:0]   prod_ff, prod_in;
   logic signed [T_W-1:0]   target_ff, target_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic [RATE_W-1:0]       alpha, gamma, one_minus;
   logic signed [A_W-1:0]   mul_a;
   logic signed [B_W-1:0]   mul_b;
   logic signed [P_W-1:0]   g_sum;
   logic signed [GR_W-1:0]  g_rnd;
   logic signed [ACC_W-1:0] a_sum;
   logic signed [AR_W-1:0]  a_rnd;

   // rates above one clamp to one
   assign alpha     = (cfg.learn_rate > ONE_Q16) ? ONE_Q16 : cfg.learn_rate;
   assign gamma     = (cfg.discount > ONE_Q16) ? ONE_Q16 : cfg.discount;
   assign one_minus = ONE_Q16 - alpha;

   // round half up of the discounted max
   assign g_sum = prod_ff + P_W'(32768);
   assign g_rnd = g_sum[GR_W+15:16];

   // operand select and step registers
   always_comb begin
      q_in      = q_ff;
      prod_in   = prod_ff;
      target_in = target_ff;
      acc_in    = acc_ff;
      mul_a     = A_W'(row_max);
      mul_b     = $signed({1'b0, gamma});
      case (step)
         UPD_GAMMA: begin
            q_in    = $signed(q_rd);
            prod_in = mul_a * mul_b;
         end
         UPD_TARGET: begin
            target_in = T_W'(reward) + T_W'(g_rnd);
            mul_a     = A_W'(q_ff);
            mul_b     = $signed({1'b0, one_minus});
            prod_in   = mul_a * mul_b;
         end
         UPD_ALPHA: begin
            acc_in  = prod_ff[ACC_W-1:0];
            mul_a   = A_W'(target_ff);
            mul_b   = $signed({1'b0, alpha});
            prod_in = mul_a * mul_b;
         end
         UPD_SUM: begin
            acc_in = acc_ff + prod_ff[ACC_W-1:0];
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      prod_ff   <= prod_in;
      target_ff <= target_in;
      acc_ff    <= acc_in;
   end

   // final rounding and clamp to 32 bits
   assign a_sum = acc_ff + ACC_W'(32768);
   assign a_rnd = a_sum[ACC_W-1:16];

   always_comb begin
      if (a_rnd > AR_W'(32'sh7FFF_FFFF)) begin
         new_value = 32'h7FFF_FFFF;
      end else if (a_rnd < -AR_W'(33'sh0_8000_0000)) begin
         new_value = 32'h8000_0000;
      end else begin
         new_value = a_rnd[Q_W-1:0];
      end
   end

endmodule

@@ rtl/core/tabular_q_learning_engine_core.sv @@
// Top level of the tabular Q-learning engine: item sequencer, row scan and choice.
// Depends on qle_pkg, qle_csr, qle_table and qle_update.

// A learn item updates one Q entry and picks an epsilon-greedy action for the
// next state; a choose item only picks; a write item loads one entry. After
// reset the table is zero-filled with busy high; register writes are taken
// during that time. Items are accepted when start is high and busy low, and
// each gives one result, strobed on rsp_valid for a single cycle with no
// back-pressure. A choose item scans its row; a learn item scans the next
// state's row, then reads, updates and writes its entry if the action is in
// range, and scans again when the updated row is the next state's row; a write
// item loads its entry. The scan reads one entry a cycle through the single
// memory read port, and the update uses the shared multiplier three times.
module tabular_q_learning_engine_core import qle_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   eng_state_type         state_ff, state_in;
   req_type               item_ff, item_in;
   logic [STATE_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  pend_ff, pend_in;
   logic [COL_W-1:0]      pend_col_ff, pend_col_in;
   logic signed [Q_W-1:0] best_ff, best_in;
   logic [COL_W-1:0]      greedy_ff, greedy_in;
   logic                  upd_done_ff, upd_done_in;

   cfg_type               cfg;
   tbl_req_type           tbl_req;
   logic [Q_W-1:0]        rd_data;
   logic                  tbl_ready;
   upd_step_type          upd_step;
   logic [Q_W-1:0]        new_value;

   logic                  accept;
   logic                  last_col;
   logic                  act_ok;
   logic                  same_row;
   logic [ADDR_W-1:0]     scan_addr;
   logic [ADDR_W-1:0]     entry_addr;
   logic                  explore;
   logic [ACT_W-1:0]      rand_act;

   qle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qle_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data),
      .ready   (tbl_ready)
   );

   qle_update u_update (
      .clock     (clock),
      .step      (upd_step),
      .cfg       (cfg),
      .row_max   (best_ff),
      .q_rd      (rd_data),
      .reward    (item_ff.reward_value),
      .new_value (new_value)
   );

   // handshake and address helpers
   assign busy       = !tbl_ready || (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign last_col   = (col_ff == COL_W'(NUM_ACTIONS - 1));
   assign act_ok     = (item_ff.taken_action < ACT_W'(NUM_ACTIONS));
   assign same_row   = (item_ff.cur_state[STATE_W-1:0] == item_ff.next_state[STATE_W-1:0]);
   assign scan_addr  = ADDR_W'(row_ff) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col_ff);
   assign entry_addr = ADDR_W'(item_ff.cur_state[STATE_W-1:0]) * ADDR_W'(NUM_ACTIONS)
                       + ADDR_W'(item_ff.taken_action);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.op inside {OP_LEARN, OP_CHOOSE}) begin
                  state_in = S_SCAN;
               end else if (req_data.op == OP_WRITE) begin
                  state_in = S_WR_ENTRY;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_SCAN: begin
            if (last_col) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (item_ff.op == OP_LEARN && !upd_done_ff && act_ok) begin
               state_in = S_READ_Q;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_READ_Q:   state_in = S_MUL_G;
         S_MUL_G:    state_in = S_TARGET;
         S_TARGET:   state_in = S_MUL_A;
         S_MUL_A:    state_in = S_SUM;
         S_SUM:      state_in = S_WRITE;
         S_WRITE: begin
            if (same_row) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_WR_ENTRY: state_in = S_RESULT;
         S_RESULT:   state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: table port, update step and item registers
   always_comb begin
      item_in       = item_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pend_in       = 1'b0;
      pend_col_in   = col_ff;
      upd_done_in   = upd_done_ff;
      upd_step      = UPD_IDLE;
      tbl_req.we    = 1'b0;
      tbl_req.waddr = entry_addr;
      tbl_req.wdata = item_ff.entry_value;
      tbl_req.raddr = scan_addr;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in     = req_data;
               col_in      = '0;
               upd_done_in = 1'b0;
               if (req_data.op == OP_CHOOSE) begin
                  row_in = req_data.cur_state[STATE_W-1:0];
               end else begin
                  row_in = req_data.next_state[STATE_W-1:0];
               end
            end
         end
         S_SCAN: begin
            pend_in     = 1'b1;
            pend_col_in = col_ff;
            col_in      = last_col ? '0 : col_ff + 1'b1;
         end
         S_READ_Q: begin
            tbl_req.raddr = entry_addr;
         end
         S_MUL_G:  upd_step = UPD_GAMMA;
         S_TARGET: upd_step = UPD_TARGET;
         S_MUL_A:  upd_step = UPD_ALPHA;
         S_SUM:    upd_step = UPD_SUM;
         S_WRITE: begin
            tbl_req.we    = 1'b1;
            tbl_req.wdata = new_value;
            upd_done_in   = 1'b1;
            col_in        = '0;
         end
         S_WR_ENTRY: begin
            tbl_req.we = act_ok;
         end
         default: begin
            upd_step = UPD_IDLE;
         end
      endcase
   end

   // running row maximum, first index wins ties
   always_comb begin
      best_in   = best_ff;
      greedy_in = greedy_ff;
      if (pend_ff) begin
         if (pend_col_ff == '0 || $signed(rd_data) > best_ff) begin
            best_in   = $signed(rd_data);
            greedy_in = pend_col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_ff     <= 1'b0;
         upd_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         upd_done_ff <= upd_done_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      pend_col_ff <= pend_col_in;
      best_ff     <= best_in;
      greedy_ff   <= greedy_in;
   end

   // epsilon-greedy choice
   assign explore  = ({1'b0, item_ff.explore_draw} < cfg.explore_threshold);
   assign rand_act = (item_ff.random_action >= ACT_W'(NUM_ACTIONS))
                     ? item_ff.random_action - ACT_W'(NUM_ACTIONS)
                     : item_ff.random_action;

   // result
   assign rsp_valid = (state_ff == S_RESULT);

   always_comb begin
      rsp_data = '0;
      if (item_ff.op inside {OP_LEARN, OP_CHOOSE}) begin
         rsp_data.explored      = explore;
         rsp_data.chosen_action = explore ? rand_act : ACT_W'(greedy_ff);
         rsp_data.best_value    = best_ff;
      end
   end

endmodule

@@ verif/tb_tabular_q_learning_engine_core.sv @@
// Self-checking testbench of tabular_q_learning_engine_core: Q updates, row max and
// epsilon-greedy choice are mirrored in a local table and compared on every result strobe.
// Depends on qle_pkg and the core RTL only.
module tb_tabular_q_learning_engine_core;
   import qle_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;
   localparam logic signed [Q_W-1:0] Q_ONE = 32'sd65536;
   localparam longint SAT_HI = 64'sh7FFFFFFF;
   localparam longint SAT_LO = -64'sh80000000;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 240;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;

   // mirrored engine state
   logic signed [Q_W-1:0] q_mirror [TABLE_DEPTH];
   logic [RATE_W-1:0]     rate_alpha;
   logic [RATE_W-1:0]     rate_gamma;
   logic [RATE_W-1:0]     rate_epsilon;
   rsp_type               awaited_choices [$];

   int errors;
   int results_checked;
   int cycle_count;
   int op_count [4];
   int rate_settings;
   int burst_left;
   int walk_pos;

   tabular_q_learning_engine_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  awaited_choices.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // print stays bounded even when the engine is badly broken
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 100)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // (x + 0.5) in Q16, floored
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // row maximum, first column wins ties
   function automatic void scan_row(input int row, output logic signed [Q_W-1:0] peak,
                                    output int idx);
      peak = q_mirror[row * NUM_ACTIONS];
      idx = 0;
      for (int col = 1; col < NUM_ACTIONS; col++) begin
         if (q_mirror[row * NUM_ACTIONS + col] > peak) begin
            peak = q_mirror[row * NUM_ACTIONS + col];
            idx = col;
         end
      end
   endfunction

   // applies one item to the mirror and returns the result it must produce
   function automatic rsp_type learn_and_choose(input req_type it);
      rsp_type res;
      int cur, nxt, row, greedy, slot;
      logic signed [Q_W-1:0] peak, best;
      longint alpha, gamma, target, acc, upd;
      res = '0;
      cur = it.cur_state % NUM_STATES;
      nxt = it.next_state % NUM_STATES;
      if (it.op == OP_WRITE) begin
         if (it.taken_action < NUM_ACTIONS)
            q_mirror[cur * NUM_ACTIONS + it.taken_action] = it.entry_value;
         return res;
      end
      if (it.op == OP_UNUSED)
         return res;
      row = cur;
      if (it.op == OP_LEARN) begin
         scan_row(nxt, peak, greedy);
         if (it.taken_action < NUM_ACTIONS) begin
            alpha = longint'((rate_alpha > ONE_Q16) ? ONE_Q16 : rate_alpha);
            gamma = longint'((rate_gamma > ONE_Q16) ? ONE_Q16 : rate_gamma);
            slot = cur * NUM_ACTIONS + it.taken_action;
            target = longint'($signed(it.reward_value)) + round_q16(gamma * longint'(peak));
            acc = (65536 - alpha) * longint'(q_mirror[slot]) + alpha * target;
            upd = round_q16(acc);
            if (upd > SAT_HI)
               upd = SAT_HI;
            else if (upd < SAT_LO)
               upd = SAT_LO;
            q_mirror[slot] = upd[Q_W-1:0];
         end
         row = nxt;
      end
      scan_row(row, best, greedy);
      if (it.explore_draw < rate_epsilon) begin
         res.chosen_action = ACT_W'(it.random_action % NUM_ACTIONS);
         res.explored = 1'b1;
      end else begin
         res.chosen_action = ACT_W'(greedy);
      end
      res.best_value = best;
      return res;
   endfunction

   // result checker: no back-pressure, every strobe is one result
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_choices.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding: %p", rsp_data));
         end else begin
            want = awaited_choices.pop_front();
            results_checked++;
            if (rsp_data.chosen_action !== want.chosen_action)
               report_mismatch($sformatf("chosen_action %0d, want %0d",
                                         rsp_data.chosen_action, want.chosen_action));
            if (rsp_data.explored !== want.explored)
               report_mismatch($sformatf("explored %b, want %b",
                                         rsp_data.explored, want.explored));
            if (rsp_data.best_value !== want.best_value)
               report_mismatch($sformatf("best_value %h, want %h",
                                         rsp_data.best_value, want.best_value));
         end
      end
   end

   // mostly short gaps, some long ones, and bursts with none
   function automatic int idle_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(10, 50);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // one item: hold start until the engine takes it, then predict
   task automatic send_item(input req_type item);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_choices.push_back(learn_and_choose(item));
      op_count[item.op]++;
   endtask

   // stop issuing and wait for every result and for the engine to go idle
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (awaited_choices.size() != 0 || busy !== 1'b0);
   endtask

   // register write followed by a read back
   task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
      logic [RATE_W-1:0] kept;
      kept = value[RATE_W-1:0];
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_LEARN_RATE: rate_alpha = kept;
         REG_DISCOUNT:   rate_gamma = kept;
         REG_EXPLORE:    rate_epsilon = kept;
         default:        ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== {{(PDATA_W-RATE_W){1'b0}}, kept})
         report_mismatch($sformatf("register %0d reads %h, want %h", idx, csr_prdata, kept));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_rates(input logic [PDATA_W-1:0] alpha, input logic [PDATA_W-1:0] gamma,
                            input logic [PDATA_W-1:0] epsilon);
      drain_results();
      write_reg(REG_LEARN_RATE, alpha);
      write_reg(REG_DISCOUNT, gamma);
      write_reg(REG_EXPLORE, epsilon);
      rate_settings++;
   endtask

   function automatic req_type make_req(input logic [OP_W-1:0] op, input int cur, input int act,
                                        input logic signed [Q_W-1:0] reward, input int nxt,
                                        input int draw, input int ract,
                                        input logic signed [Q_W-1:0] entry);
      req_type it;
      it.op = op;
      it.cur_state = SIDX_W'(cur);
      it.taken_action = ACT_W'(act);
      it.reward_value = reward;
      it.next_state = SIDX_W'(nxt);
      it.explore_draw = DRAW_W'(draw);
      it.random_action = ACT_W'(ract);
      it.entry_value = entry;
      return it;
   endfunction

   // Q16.16 values: mostly within +-16.0, some anywhere, a few at the limits or near zero
   function automatic logic signed [Q_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         7, 8:    return $urandom;
         9: begin
            case ($urandom_range(0, 3))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return '0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(0, 2097152)) - 1048576;
      endcase
   endfunction

   // states cluster on a few rows so values build up
   function automatic int pick_state();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
   endfunction

   function automatic logic [PDATA_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 65536;
         2:       return $urandom_range(65537, 17'h1FFFF);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   // episode walk: most items start where the previous learn item on the walk ended
   function automatic req_type random_item();
      req_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         it.op = OP_LEARN;
      else if (r < 78)
         it.op = OP_CHOOSE;
      else if (r < 95)
         it.op = OP_WRITE;
      else
         it.op = OP_UNUSED;
      it.taken_action = ACT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                           : $urandom_range(0, 4));
      it.reward_value = pick_value();
      it.entry_value = pick_value();
      it.explore_draw = DRAW_W'($urandom);
      it.random_action = ACT_W'($urandom_range(0, 7));
      it.next_state = SIDX_W'(pick_state());
      if ($urandom_range(0, 99) < 85) begin
         it.cur_state = SIDX_W'(walk_pos);
         if (it.op == OP_LEARN)
            walk_pos = int'(it.next_state);
      end else begin
         it.cur_state = SIDX_W'($urandom_range(0, 255));
      end
      return it;
   endfunction

   // fresh table at the reset rates
   task automatic test_cleared_table();
      send_item(make_req(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(OP_CHOOSE, 255, 0, 0, 0, 0, 0, 0));
      send_item(make_req(OP_LEARN, 0, 0, Q_ONE, 0, 65535, 0, 0));
   endtask

   // entry loads, ties, out-of-range columns, unused opcode
   task automatic test_entry_writes();
      send_item(make_req(OP_WRITE, 3, 4, 0, 0, 0, 0, Q_MAX));
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 0, 0, 0));
      send_item(make_req(OP_WRITE, 3, 1, 0, 0, 0, 0, Q_MAX));
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 0, 0, 0));
      send_item(make_req(OP_WRITE, 3, 5, 0, 0, 0, 0, Q_MIN));
      send_item(make_req(OP_WRITE, 3, 7, 0, 0, 0, 0, Q_MIN));
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 0, 0, 0));
      send_item(make_req(OP_UNUSED, 255, 7, -1, 255, 65535, 7, -1));
   endtask

   // alpha one, gamma above one: updates that clip at both ends
   task automatic test_update_saturation();
      set_rates(65536, 32'h1FFFF, 0);
      send_item(make_req(OP_LEARN, 3, 0, Q_MAX, 3, 0, 0, 0));
      for (int col = 0; col < NUM_ACTIONS; col++)
         send_item(make_req(OP_WRITE, 4, col, 0, 0, 0, 0, Q_MIN));
      send_item(make_req(OP_LEARN, 4, 0, Q_MIN, 4, 0, 0, 0));
      send_item(make_req(OP_LEARN, 4, 6, Q_MAX, 3, 0, 0, 0));
   endtask

   // exploration at threshold edges, random action wrap
   task automatic test_exploration();
      set_rates(65536, 65536, 65536);
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 65535, 7, 0));
      set_rates(65536, 65536, 32768);
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 32767, 4, 0));
      send_item(make_req(OP_CHOOSE, 3, 0, 0, 0, 32768, 4, 0));
      set_rates(65536, 65536, 32'h1FFFF);
      send_item(make_req(OP_LEARN, 0, 1, Q_MIN, 3, 65535, 5, 0));
   endtask

   // alpha zero leaves the entry alone; unused write data bits are dropped
   task automatic test_register_limits();
      set_rates(0, 0, 0);
      send_item(make_req(OP_LEARN, 3, 4, Q_MAX, 3, 0, 0, 0));
      set_rates(32'hFFFE_0000 | 32'h10000, 32'hFFFE_0000, 32'hFFFE_0000 | 32'h1FFFF);
   endtask

   // episode walks under several rate settings
   task automatic test_random_learning();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       set_rates(PDATA_W'(LEARN_RATE_RST), PDATA_W'(DISCOUNT_RST), 6554);
            1:       set_rates(65536, 65536, 0);
            2:       set_rates(32'h1FFFF, 32'h1FFFF, 32768);
            3:       set_rates(0, 0, 65536);
            default: set_rates(pick_rate(), pick_rate(), $urandom_range(0, 20000));
         endcase
         walk_pos = pick_state();
         repeat (PHASE_ITEMS) send_item(random_item());
      end
   endtask

   initial begin
      foreach (q_mirror[i])
         q_mirror[i] = '0;
      rate_alpha = LEARN_RATE_RST;
      rate_gamma = DISCOUNT_RST;
      rate_epsilon = EXPLORE_RST;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_cleared_table();
      test_entry_writes();
      test_update_saturation();
      test_exploration();
      test_register_limits();
      test_random_learning();

      drain_results();
      repeat (30) @(posedge clock);
      if (awaited_choices.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_choices.size()));

      $display("items: %0d learn, %0d choose, %0d write, %0d unused opcode; %0d rate settings",
               op_count[OP_LEARN], op_count[OP_CHOOSE], op_count[OP_WRITE],
               op_count[OP_UNUSED], rate_settings);
      $display("%0d results checked, %0d mismatches", results_checked, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
